>>> rtl/rwhp_pkg.sv
// Shared types, constants and tag tables for the RIFF/WAVE header parser.
package rwhp_pkg;

	localparam logic [23:0] MAX_FILE_BYTES = 24'd10485760;
	localparam logic [23:0] MIN_WAVE_BYTES = 24'd44;
	localparam logic [23:0] FMT_MIN_BYTES  = 24'd16;
	localparam logic [23:0] HDR_LAST_POS   = 24'd11;
	localparam logic [31:0] TAG_FMT        = 32'h666D7420;
	localparam logic [31:0] TAG_DATA       = 32'h64617461;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CHDR,
		PH_SKIP,
		PH_FMT,
		PH_DATA,
		PH_END_NODATA,
		PH_END_NOTWAVE,
		PH_END_DATA
	} phase_t;

	typedef enum logic [1:0] {
		ST_LOADED,
		ST_BAD_SIZE,
		ST_NOT_WAVE,
		ST_NO_DATA
	} status_t;

	typedef enum logic {
		KIND_SAMPLE,
		KIND_STATUS
	} kind_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [23:0] file_size;
	} item_t;

	typedef struct packed {
		kind_t              result_kind;
		logic signed [15:0] sample_value;
		logic [15:0]        channel_count;
		logic [31:0]        sample_rate_hz;
		logic [22:0]        sample_total;
		status_t            parse_status;
		logic               last_of_run;
	} res_t;

	// "RIFF" at offsets 0..3, "WAVE" at offsets 8..11
	function automatic logic [7:0] riff_byte(input logic [1:0] idx);
		case (idx)
			2'd0:    riff_byte = 8'h52;
			2'd1:    riff_byte = 8'h49;
			2'd2:    riff_byte = 8'h46;
			default: riff_byte = 8'h46;
		endcase
	endfunction

	function automatic logic [7:0] wave_byte(input logic [1:0] idx);
		case (idx)
			2'd0:    wave_byte = 8'h57;
			2'd1:    wave_byte = 8'h41;
			2'd2:    wave_byte = 8'h56;
			default: wave_byte = 8'h45;
		endcase
	endfunction

endpackage

>>> rtl/rwhp_outq.sv
// Four-entry result queue: up to two pushes per cycle, one pop.
module rwhp_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     push_cnt,
	input  rwhp_pkg::res_t push0,
	input  rwhp_pkg::res_t push1,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output rwhp_pkg::res_t out_res
);
	import rwhp_pkg::*;

	res_t       ent_q [4];
	logic [1:0] head_q;
	logic [1:0] tail_q;
	logic [2:0] count_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 3'd0);
	assign out_res   = ent_q[head_q];
	// two free slots guaranteed before the core may fire
	assign room      = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			ent_q[tail_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			ent_q[tail_q + 2'd1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 2'd1;
			end
			tail_q  <= tail_q + push_cnt;
			count_q <= count_q + {1'b0, push_cnt} - {2'b0, pop};
		end
	end

endmodule

>>> rtl/rwhp_core.sv
// Parser state and per-byte update; forms up to two results per byte.
module rwhp_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  rwhp_pkg::item_t item,
	output logic [1:0]      res_cnt,
	output rwhp_pkg::res_t  res0,
	output rwhp_pkg::res_t  res1
);
	import rwhp_pkg::*;

	phase_t      ph_q, ph_e, ph_d;
	logic [23:0] off_q, off_e, off_d;
	logic [23:0] cap_q, cap_e;
	logic [31:0] tag_q, tag_e, tag_d;
	logic [31:0] len_q, len_e, len_d;
	logic [23:0] left_q, left_e, left_d;
	logic [15:0] ch_q, ch_e, ch_d;
	logic [31:0] rate_q, rate_e, rate_d;
	logic [7:0]  pend_q, pend_e, pend_d;
	logic        fin_q, fin_e, fin_d;

	logic [24:0] next;
	logic [23:0] left_m1;
	logic [31:0] len_v;
	logic [23:0] room_b;
	logic [23:0] lenc;
	logic [23:0] idx;
	logic [2:0]  k;
	logic        enter;
	logic        emit;
	logic        bad;
	logic [15:0] smp;
	status_t     st;
	res_t        r_smp, r_st;

	// restart on first byte
	always_comb begin
		ph_e   = ph_q;
		off_e  = off_q;
		cap_e  = cap_q;
		tag_e  = tag_q;
		len_e  = len_q;
		left_e = left_q;
		ch_e   = ch_q;
		rate_e = rate_q;
		pend_e = pend_q;
		fin_e  = fin_q;
		if (item.first_byte) begin
			off_e  = '0;
			cap_e  = item.file_size;
			tag_e  = '0;
			len_e  = '0;
			left_e = '0;
			ch_e   = '0;
			rate_e = '0;
			pend_e = '0;
			fin_e  = 1'b0;
			if (item.file_size == '0 || item.file_size > MAX_FILE_BYTES) begin
				ph_e = PH_END_NODATA;
			end else if (item.file_size < MIN_WAVE_BYTES) begin
				ph_e = PH_END_NOTWAVE;
			end else begin
				ph_e = PH_HEADER;
			end
		end
	end

	assign bad     = (cap_e == '0) || (cap_e > MAX_FILE_BYTES);
	assign next    = {1'b0, off_e} + 25'd1;
	assign left_m1 = left_e - 24'd1;
	assign k       = 3'(4'd8 - {1'b0, left_e[2:0]});
	assign idx     = len_e[23:0] - left_e;
	assign room_b  = ({1'b0, cap_e} > next) ? 24'({1'b0, cap_e} - next) : '0;

	always_comb begin
		len_v = len_e;
		if (k[2]) begin
			case (k[1:0])
				2'd0:    len_v[7:0]   = len_e[7:0] | item.data_byte;
				2'd1:    len_v[15:8]  = len_e[15:8] | item.data_byte;
				2'd2:    len_v[23:16] = len_e[23:16] | item.data_byte;
				default: len_v[31:24] = len_e[31:24] | item.data_byte;
			endcase
		end
		lenc = (len_v > {8'b0, room_b}) ? room_b : len_v[23:0];
	end

	// byte processing
	always_comb begin
		ph_d   = ph_e;
		tag_d  = tag_e;
		len_d  = len_e;
		left_d = left_e;
		ch_d   = ch_e;
		rate_d = rate_e;
		pend_d = pend_e;
		enter  = 1'b0;
		emit   = 1'b0;
		smp    = '0;
		case (ph_e)
			PH_HEADER: begin
				if (off_e < 24'd4) begin
					if (item.data_byte != riff_byte(off_e[1:0])) ph_d = PH_END_NOTWAVE;
				end else if (off_e >= 24'd8 && off_e <= HDR_LAST_POS) begin
					if (item.data_byte != wave_byte(off_e[1:0])) ph_d = PH_END_NOTWAVE;
				end
				if (ph_d == PH_HEADER && off_e == HDR_LAST_POS) enter = 1'b1;
			end
			PH_CHDR: begin
				if (!k[2]) tag_d = {tag_e[23:0], item.data_byte};
				len_d  = len_v;
				left_d = left_m1;
				if (left_m1 == '0) begin
					len_d = {8'b0, lenc};
					if (tag_d == TAG_DATA) begin
						if (lenc < 24'd2) begin
							ph_d = PH_END_NODATA;
						end else begin
							ph_d   = PH_DATA;
							left_d = {lenc[23:1], 1'b0};
						end
					end else if (tag_d == TAG_FMT && lenc >= FMT_MIN_BYTES) begin
						ph_d   = PH_FMT;
						left_d = lenc;
					end else begin
						ph_d   = PH_SKIP;
						left_d = lenc;
						if (lenc == '0) enter = 1'b1;
					end
				end
			end
			PH_FMT: begin
				case (idx)
					24'd2: ch_d = {8'b0, item.data_byte};
					24'd3: ch_d = ch_e | {item.data_byte, 8'b0};
					24'd4: rate_d = {24'b0, item.data_byte};
					24'd5: rate_d = rate_e | {16'b0, item.data_byte, 8'b0};
					24'd6: rate_d = rate_e | {8'b0, item.data_byte, 16'b0};
					24'd7: rate_d = rate_e | {item.data_byte, 24'b0};
					default: ;
				endcase
				left_d = left_m1;
				if (left_m1 == '0) enter = 1'b1;
			end
			PH_SKIP: begin
				left_d = left_m1;
				if (left_m1 == '0) enter = 1'b1;
			end
			PH_DATA: begin
				if (!left_e[0]) begin
					pend_d = item.data_byte;
				end else begin
					smp  = {item.data_byte, pend_e};
					emit = 1'b1;
				end
				left_d = left_m1;
				if (left_m1 == '0) ph_d = PH_END_DATA;
			end
			default: ;
		endcase
		if (enter) begin
			if ({1'b0, next} + 26'd8 < {2'b0, cap_e}) begin
				ph_d   = PH_CHDR;
				left_d = 24'd8;
				tag_d  = '0;
				len_d  = '0;
			end else begin
				ph_d = PH_END_NODATA;
			end
		end
	end

	always_comb begin
		if (bad) begin
			st = ST_BAD_SIZE;
		end else if (ph_d == PH_HEADER || ph_d == PH_END_NOTWAVE) begin
			st = ST_NOT_WAVE;
		end else if (ph_d == PH_END_DATA) begin
			st = ST_LOADED;
		end else begin
			st = ST_NO_DATA;
		end
	end

	always_comb begin
		r_smp.result_kind    = KIND_SAMPLE;
		r_smp.sample_value   = smp;
		r_smp.channel_count  = ch_d;
		r_smp.sample_rate_hz = rate_d;
		r_smp.sample_total   = (ph_d == PH_DATA || ph_d == PH_END_DATA) ? len_d[23:1] : '0;
		r_smp.parse_status   = ST_LOADED;
		r_smp.last_of_run    = !item.last_byte;
		r_st                 = r_smp;
		r_st.result_kind     = KIND_STATUS;
		r_st.sample_value    = '0;
		r_st.parse_status    = st;
		r_st.last_of_run     = 1'b1;
	end

	always_comb begin
		res0    = emit ? r_smp : r_st;
		res1    = r_st;
		res_cnt = '0;
		if (step && !fin_e) begin
			res_cnt = {1'b0, emit} + {1'b0, item.last_byte};
		end
	end

	assign fin_d = fin_e || item.last_byte;
	assign off_d = (off_e < 24'hFFFFFF) ? off_e + 24'd1 : off_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_HEADER;
			off_q  <= '0;
			cap_q  <= '0;
			tag_q  <= '0;
			len_q  <= '0;
			left_q <= '0;
			ch_q   <= '0;
			rate_q <= '0;
			pend_q <= '0;
			fin_q  <= 1'b0;
		end else if (step) begin
			cap_q <= cap_e;
			if (fin_e) begin
				ph_q   <= ph_e;
				off_q  <= off_e;
				tag_q  <= tag_e;
				len_q  <= len_e;
				left_q <= left_e;
				ch_q   <= ch_e;
				rate_q <= rate_e;
				pend_q <= pend_e;
				fin_q  <= fin_e;
			end else begin
				ph_q   <= ph_d;
				off_q  <= off_d;
				tag_q  <= tag_d;
				len_q  <= len_d;
				left_q <= left_d;
				ch_q   <= ch_d;
				rate_q <= rate_d;
				pend_q <= pend_d;
				fin_q  <= fin_d;
			end
		end
	end

endmodule

>>> rtl/riff_wave_header_parser.sv
// Top level of the byte-serial RIFF/WAVE header parser.
//
// Usage:
//  - Slave channel s_*: one file byte per item. s_tuser marks the first byte
//    of a file (parser restarts, s_tdata carries the file size), s_tlast the
//    final byte. Sizes of 0 or above 10 MiB are rejected as bad size.
//  - Master channel m_*: result items. m_tuser is 0 for an audio sample,
//    1 for the closing status; m_tlast marks the last result of a byte.
//  - A byte gives no result, one sample, one status, or sample then status.
// Timing:
//  - Input register, combinational parse logic, then a 4-entry result queue.
//    A result is written into the queue from the input register and is then
//    shown on m_*; a full queue holds its byte in the input register.
//  - One byte per cycle sustained while the queue has room; a byte that
//    yields two results takes an extra output slot, absorbed by the queue.
//  - When the receiver stalls, the queue fills and s_tready drops once fewer
//    than two entries are free; nothing is lost or repeated.
// Reset:
//  - arst_n clears the parser; with no first byte seen, a last byte reports
//    bad size. The queue and input register come up empty.
module riff_wave_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [7:0] data_byte, [31:8] file_size
	input  logic        s_tuser,  // first_byte
	input  logic        s_tlast,  // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] sample_value, [31:16] channel_count, [63:32] sample_rate_hz,
	// [86:64] sample_total, [88:87] parse_status, [95:89] zero
	output logic [95:0] m_tdata,
	output logic        m_tuser,  // result_kind
	output logic        m_tlast   // last_of_run
);
	import rwhp_pkg::*;

	item_t      item_s1;
	logic       valid_s1;
	logic       room;
	logic       fire;
	logic       take;
	logic [1:0] res_cnt;
	res_t       res0, res1, out_res;

	// byte fires into the core only when the queue can hold two results
	assign fire     = valid_s1 && room;
	assign s_tready = !valid_s1 || fire;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte  <= s_tdata[7:0];
			item_s1.first_byte <= s_tuser;
			item_s1.last_byte  <= s_tlast;
			item_s1.file_size  <= s_tdata[31:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	rwhp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (fire),
		.item    (item_s1),
		.res_cnt (res_cnt),
		.res0    (res0),
		.res1    (res1)
	);

	rwhp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (res_cnt),
		.push0     (res0),
		.push1     (res1),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {7'b0, out_res.parse_status, out_res.sample_total,
		out_res.sample_rate_hz, out_res.channel_count, out_res.sample_value};
	assign m_tuser = out_res.result_kind;
	assign m_tlast = out_res.last_of_run;

endmodule

>>> dv/tb_riff_wave_header_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench: random WAV byte streams through the parser, checked against a predictor.
module tb_riff_wave_header_parser;
	import rwhp_pkg::*;

	localparam logic [31:0] RIFF_TAG = 32'h52494646;
	localparam logic [31:0] WAVE_TAG = 32'h57415645;
	// Longest quiet stretch of a correct run is the forced sink hold plus the
	// result latency; the limit leaves a wide margin over that.
	localparam int QUIET_LIMIT     = 4000;
	localparam int HOLD_CYCLES     = 300;
	localparam int ITEMS_PER_PHASE = 400;
	localparam int TAIL_CYCLES     = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;  // [7:0] data_byte, [31:8] file_size
	logic        s_tuser = 1'b0; // first_byte
	logic        s_tlast = 1'b0; // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;        // sample, channels, rate, total, status from bit 0 up
	logic        m_tuser;        // result_kind
	logic        m_tlast;        // last_of_run

	// stimulus and scoreboard
	item_t file_bytes_q[$];
	res_t  parse_results_due[$];
	int    items_queued = 0;
	int    mismatches = 0;
	int    src_idle_pct = 0;
	int    sink_stall_pct = 0;
	int    hold_requests = 0;
	int    hold_served = 0;
	int    hold_left = 0;
	int    quiet_cycles = 0;

	// predictor state
	phase_t      wp_phase;
	logic [23:0] wp_pos;
	logic [23:0] wp_size;
	logic [31:0] wp_tag;
	logic [31:0] wp_len;     // clamped length of the current chunk
	logic [31:0] wp_left;
	logic [15:0] wp_chans;
	logic [31:0] wp_rate;
	logic [7:0]  wp_low;
	logic [22:0] wp_count;
	logic        wp_closed;

	riff_wave_header_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic wp_size_bad();
		return wp_size == 24'd0 || wp_size > MAX_FILE_BYTES;
	endfunction

	function automatic void restart_parse();
		wp_phase = PH_HEADER;
		wp_pos = '0;
		wp_tag = '0;
		wp_len = '0;
		wp_left = '0;
		wp_chans = '0;
		wp_rate = '0;
		wp_low = '0;
		wp_count = '0;
		wp_closed = 1'b0;
	endfunction

	// Another chunk header only if it would leave at least one body byte.
	function automatic void open_next_chunk(input logic [31:0] nxt);
		if ({1'b0, nxt} + 33'd8 < {9'd0, wp_size}) begin
			wp_phase = PH_CHDR;
			wp_left = 32'd8;
			wp_tag = '0;
			wp_len = '0;
		end else begin
			wp_phase = PH_END_NODATA;
		end
	endfunction

	function automatic status_t closing_status();
		if (wp_size_bad())
			return ST_BAD_SIZE;
		if (wp_phase == PH_HEADER || wp_phase == PH_END_NOTWAVE)
			return ST_NOT_WAVE;
		if (wp_phase == PH_END_DATA)
			return ST_LOADED;
		return ST_NO_DATA;
	endfunction

	function automatic res_t make_result(input kind_t kind, input logic [15:0] smp,
			input status_t st, input logic is_last);
		res_t r;
		r.result_kind = kind;
		r.sample_value = smp;
		r.channel_count = wp_chans;
		r.sample_rate_hz = wp_rate;
		// sample total is only reported once the data chunk was entered
		r.sample_total = (wp_phase == PH_DATA || wp_phase == PH_END_DATA) ? wp_len[23:1] : '0;
		r.parse_status = st;
		r.last_of_run = is_last;
		return r;
	endfunction

	function automatic void parse_file_byte(input item_t it);
		logic [31:0] pos;
		logic [31:0] nxt;
		logic [31:0] room;
		logic [31:0] idx;
		logic [15:0] smp;
		logic        emit;
		emit = 1'b0;
		smp = '0;
		if (it.first_byte) begin
			restart_parse();
			wp_size = it.file_size;
			if (wp_size_bad())
				wp_phase = PH_END_NODATA;
			else if (wp_size < MIN_WAVE_BYTES)
				wp_phase = PH_END_NOTWAVE;
		end
		if (wp_closed)
			return;
		pos = {8'd0, wp_pos};
		nxt = pos + 32'd1;
		case (wp_phase)
			PH_HEADER: begin
				if (pos < 32'd4) begin
					if (it.data_byte != RIFF_TAG[8 * (3 - int'(pos[1:0])) +: 8])
						wp_phase = PH_END_NOTWAVE;
				end else if (pos >= 32'd8 && pos < 32'd12) begin
					if (it.data_byte != WAVE_TAG[8 * (3 - int'(pos[1:0])) +: 8])
						wp_phase = PH_END_NOTWAVE;
				end
				if (wp_phase == PH_HEADER && pos == {8'd0, HDR_LAST_POS})
					open_next_chunk(nxt);
			end
			PH_CHDR: begin
				// tag big-endian in the first four bytes, length little-endian after
				idx = 32'd8 - wp_left;
				if (idx[2:0] < 3'd4)
					wp_tag = {wp_tag[23:0], it.data_byte};
				else
					wp_len = wp_len | ({24'd0, it.data_byte} << (8 * int'(idx[1:0])));
				wp_left = wp_left - 32'd1;
				if (wp_left == 32'd0) begin
					room = ({8'd0, wp_size} > nxt) ? {8'd0, wp_size} - nxt : 32'd0;
					if (wp_len > room)
						wp_len = room;
					if (wp_tag == TAG_DATA) begin
						wp_count = '0;
						if (wp_len[31:1] == '0) begin
							wp_phase = PH_END_NODATA;
						end else begin
							wp_phase = PH_DATA;
							wp_left = {wp_len[31:1], 1'b0}; // odd tail byte dropped
						end
					end else if (wp_tag == TAG_FMT && wp_len >= {8'd0, FMT_MIN_BYTES}) begin
						wp_phase = PH_FMT;
						wp_left = wp_len;
					end else begin
						wp_phase = PH_SKIP;
						wp_left = wp_len;
						if (wp_len == 32'd0)
							open_next_chunk(nxt);
					end
				end
			end
			PH_FMT: begin
				idx = wp_len - wp_left;
				case (idx)
					32'd2:   wp_chans = {8'd0, it.data_byte};
					32'd3:   wp_chans = wp_chans | {it.data_byte, 8'd0};
					32'd4:   wp_rate = {24'd0, it.data_byte};
					32'd5, 32'd6, 32'd7:
						wp_rate = wp_rate | ({24'd0, it.data_byte} << (8 * (idx - 32'd4)));
					default: ;
				endcase
				wp_left = wp_left - 32'd1;
				if (wp_left == 32'd0)
					open_next_chunk(nxt);
			end
			PH_SKIP: begin
				wp_left = wp_left - 32'd1;
				if (wp_left == 32'd0)
					open_next_chunk(nxt);
			end
			PH_DATA: begin
				if (!wp_left[0]) begin
					wp_low = it.data_byte;
				end else begin
					smp = {it.data_byte, wp_low};
					wp_count = wp_count + 23'd1;
					emit = 1'b1;
				end
				wp_left = wp_left - 32'd1;
				if (wp_left == 32'd0)
					wp_phase = PH_END_DATA;
			end
			default: ;
		endcase
		if (wp_pos != 24'hFFFFFF)
			wp_pos = wp_pos + 24'd1;
		if (emit)
			parse_results_due.push_back(make_result(KIND_SAMPLE, smp, ST_LOADED,
				!it.last_byte));
		if (it.last_byte) begin
			parse_results_due.push_back(make_result(KIND_STATUS, 16'd0, closing_status(), 1'b1));
			wp_closed = 1'b1;
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic void queue_byte(input logic [7:0] b, input logic first,
			input logic is_last, input logic [23:0] fsize);
		file_bytes_q.push_back({b, first, is_last, fsize});
		items_queued++;
	endfunction

	// Biased toward the byte values that make extreme samples.
	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void put_word(ref logic [7:0] img[$], input logic [31:0] w,
			input bit msb_first);
		for (int i = 0; i < 4; i++)
			img.push_back(msb_first ? w[8 * (3 - i) +: 8] : w[8 * i +: 8]);
	endfunction

	// One file: RIFF/WAVE header, a few odd chunks around an optional fmt chunk,
	// then an optional data chunk and some trailing bytes. Sizes, lengths and
	// the end of the stream are perturbed now and then.
	function automatic void queue_wave_file();
		logic [7:0]  img[$];
		logic [31:0] tag;
		logic [31:0] declared;
		logic [23:0] fsize;
		int unsigned n_junk;
		int unsigned fmt_at;
		int unsigned body;
		int unsigned total;
		int unsigned cut;
		int unsigned sel;
		bit          with_fmt;
		bit          with_last;
		tag = RIFF_TAG;
		if ($urandom_range(15) == 0)
			tag ^= 32'd1 << $urandom_range(31);
		put_word(img, tag, 1'b1);
		put_word(img, $urandom, 1'b0);
		tag = WAVE_TAG;
		if ($urandom_range(15) == 0)
			tag ^= 32'd1 << $urandom_range(31);
		put_word(img, tag, 1'b1);

		n_junk = $urandom_range(2);
		with_fmt = $urandom_range(7) != 0;
		fmt_at = $urandom_range(n_junk);
		for (int i = 0; i <= n_junk; i++) begin
			if (with_fmt && i == fmt_at) begin
				// a short fmt chunk is skipped like any other
				body = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(20, 16);
				put_word(img, TAG_FMT, 1'b1);
				put_word(img, body, 1'b0);
				repeat (body) img.push_back(rand_byte());
			end
			if (i < n_junk) begin
				body = $urandom_range(5);
				put_word(img, $urandom, 1'b1);
				put_word(img, body, 1'b0);
				repeat (body) img.push_back(rand_byte());
			end
		end

		sel = $urandom_range(9);
		if (sel != 0) begin
			body = (sel == 1) ? $urandom_range(1) : $urandom_range(40, 2);
			declared = ($urandom_range(7) == 0) ? $urandom : body;
			put_word(img, TAG_DATA, 1'b1);
			put_word(img, declared, 1'b0);
			repeat (body) img.push_back(rand_byte());
		end
		repeat ($urandom_range(3)) img.push_back(8'($urandom));

		total = img.size();
		case ($urandom_range(15))
			0: fsize = 24'(total - $urandom_range(12, 1));
			1: fsize = 24'($urandom_range(MAX_FILE_BYTES, total));
			2: begin
				case ($urandom_range(3))
					0:       fsize = MAX_FILE_BYTES;
					1:       fsize = MAX_FILE_BYTES + 24'd1;
					2:       fsize = 24'hFFFFFF;
					default: fsize = 24'd0;
				endcase
			end
			default: fsize = 24'(total);
		endcase
		cut = ($urandom_range(9) == 0) ? $urandom_range(total, 1) : total;
		with_last = $urandom_range(19) != 0;
		for (int j = 0; j < cut; j++)
			queue_byte(img[j], j == 0, with_last && j == cut - 1,
				(j == 0) ? fsize : 24'($urandom));
	endfunction

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin : driver
		item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				parse_file_byte({s_tdata[7:0], s_tuser, s_tlast, s_tdata[31:8]});
			if (!s_tvalid || s_tready) begin
				if (file_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					it = file_bytes_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {it.file_size, it.data_byte};
					s_tuser <= it.first_byte;
					s_tlast <= it.last_byte;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	function automatic void check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		res_t got;
		res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.result_kind = kind_t'(m_tuser);
				got.sample_value = m_tdata[15:0];
				got.channel_count = m_tdata[31:16];
				got.sample_rate_hz = m_tdata[63:32];
				got.sample_total = m_tdata[86:64];
				got.parse_status = status_t'(m_tdata[88:87]);
				got.last_of_run = m_tlast;
				if (parse_results_due.size() == 0) begin
					$display("%0t ns: result with nothing expected, kind %0d tdata %h",
						$time, m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = parse_results_due.pop_front();
					check_field("result_kind", want.result_kind, got.result_kind);
					check_field("sample_value", want.sample_value, got.sample_value);
					check_field("channel_count", want.channel_count, got.channel_count);
					check_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
					check_field("sample_total", want.sample_total, got.sample_total);
					check_field("parse_status", want.parse_status, got.parse_status);
					check_field("last_of_run", want.last_of_run, got.last_of_run);
				end
			end
			// a requested hold keeps the sink closed long enough to back up the input
			if (hold_served != hold_requests) begin
				hold_served <= hold_requests;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(99) >= sink_stall_pct;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t ns: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- sequence

	// Sender pause: nothing queued, nothing offered, every result back.
	task automatic wait_all_returned();
		while (file_bytes_q.size() != 0 || s_tvalid || parse_results_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin : sequencer
		int phase_start;
		wp_size = '0;
		restart_parse();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			@(negedge clk);
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 87; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 87; end
				default: begin src_idle_pct = 25; sink_stall_pct = 25; end
			endcase
			phase_start = items_queued;
			if (ph == 0) begin
				queue_byte(8'h00, 1'b0, 1'b1, 24'h000000);  // last byte, no file opened yet
				queue_byte(8'hFF, 1'b0, 1'b1, 24'hFFFFFF);  // already closed: no result
				queue_byte(8'hFF, 1'b1, 1'b1, 24'd0);       // empty file
				queue_byte(8'h52, 1'b1, 1'b1, 24'hFFFFFF);  // far too large
				queue_byte(8'h52, 1'b1, 1'b1, MAX_FILE_BYTES + 24'd1);
				queue_byte(8'h52, 1'b1, 1'b0, MAX_FILE_BYTES); // largest legal, bad tag
				queue_byte(8'h58, 1'b0, 1'b1, 24'd0);
				queue_byte(8'h52, 1'b1, 1'b1, 24'd43);      // one byte short of a header
				queue_byte(8'h52, 1'b1, 1'b0, 24'd44);      // stream ends inside header
				queue_byte(8'h49, 1'b0, 1'b0, 24'd0);
				queue_byte(8'h46, 1'b0, 1'b1, 24'd0);
				queue_byte(8'h00, 1'b0, 1'b1, 24'd0);       // after status: ignored
			end
			while (items_queued - phase_start < ITEMS_PER_PHASE) begin
				if ($urandom_range(5) == 0) begin
					// noise: random bytes with stray first and last marks
					repeat ($urandom_range(20, 1))
						queue_byte(8'($urandom), $urandom_range(9) == 0,
							$urandom_range(9) == 0, 24'($urandom));
				end else begin
					queue_wave_file();
				end
			end
			if (ph == 0)
				hold_requests = hold_requests + 1;
			wait_all_returned();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
rtl/rwhp_pkg.sv
rtl/rwhp_outq.sv
rtl/rwhp_core.sv
rtl/riff_wave_header_parser.sv
dv/tb_riff_wave_header_parser.sv
